@@ rtl/kbs_pkg.sv @@
// Shared types, constants and helper functions for the kinematic bicycle step core.
package kbs_pkg;

  localparam int CORDIC_ITERATIONS = 16;

  typedef logic signed [15:0] ang_t;
  typedef logic signed [33:0] cq_t;

  localparam ang_t ANG_PI = 16'sd25736;
  localparam logic signed [16:0] ANG_TWO_PI = 17'sd51472;
  localparam cq_t Q30_PI = 34'sd3373259426;
  localparam cq_t Q30_HALF_PI = 34'sd1686629713;
  localparam cq_t Q30_GAIN = 34'sd652032874;

  localparam cq_t ATAN_TAB [32] = '{
    34'sd843314857, 34'sd497837829, 34'sd263043837, 34'sd133525159, 34'sd67021687,
    34'sd33543516, 34'sd16775851, 34'sd8388437, 34'sd4194283, 34'sd2097149,
    34'sd1048576, 34'sd524288, 34'sd262144, 34'sd131072, 34'sd65536, 34'sd32768,
    34'sd16384, 34'sd8192, 34'sd4096, 34'sd2048, 34'sd1024, 34'sd512, 34'sd256,
    34'sd128, 34'sd64, 34'sd32, 34'sd16, 34'sd8, 34'sd4, 34'sd2, 34'sd1, 34'sd0
  };

  localparam logic [2:0] REG_STEP_TIME   = 3'd0;
  localparam logic [2:0] REG_WHEEL_BASE  = 3'd1;
  localparam logic [2:0] REG_STEER_LIMIT = 3'd2;
  localparam logic [2:0] REG_SPEED_UPPER = 3'd3;
  localparam logic [2:0] REG_SPEED_LOWER = 3'd4;
  localparam logic [2:0] REG_ACCEL_MODE  = 3'd5;

  localparam logic [3:0] OP_NONE      = 4'd0;
  localparam logic [3:0] OP_LOAD      = 4'd1;
  localparam logic [3:0] OP_TAN       = 4'd2;
  localparam logic [3:0] OP_SPEED_CMD = 4'd3;
  localparam logic [3:0] OP_SS        = 4'd4;
  localparam logic [3:0] OP_HIGH      = 4'd5;
  localparam logic [3:0] OP_XL        = 4'd6;
  localparam logic [3:0] OP_YL        = 4'd7;
  localparam logic [3:0] OP_NUM       = 4'd8;
  localparam logic [3:0] OP_DEN       = 4'd9;
  localparam logic [3:0] OP_HEAD      = 4'd10;
  localparam logic [3:0] OP_ACC_UPD   = 4'd11;
  localparam logic [3:0] OP_VX        = 4'd12;
  localparam logic [3:0] OP_VY        = 4'd13;
  localparam logic [3:0] OP_YNUM      = 4'd14;
  localparam logic [3:0] OP_YDEN      = 4'd15;

  localparam logic [3:0] M_NONE   = 4'd0;
  localparam logic [3:0] M_SS     = 4'd1;
  localparam logic [3:0] M_SS_CH  = 4'd2;
  localparam logic [3:0] M_SS_CL  = 4'd3;
  localparam logic [3:0] M_SS_SH  = 4'd4;
  localparam logic [3:0] M_SS_SL  = 4'd5;
  localparam logic [3:0] M_SS_TS  = 4'd6;
  localparam logic [3:0] M_WB_TC  = 4'd7;
  localparam logic [3:0] M_ACC_ST = 4'd8;
  localparam logic [3:0] M_SPD_C  = 4'd9;
  localparam logic [3:0] M_SPD_S  = 4'd10;
  localparam logic [3:0] M_SPD_TS = 4'd11;

  typedef struct packed {
    logic [15:0]        step_time;
    logic [15:0]        wheel_base;
    logic [13:0]        steer_limit;
    logic signed [15:0] speed_upper;
    logic signed [15:0] speed_lower;
    logic               accel_mode;
  } cfg_t;

  typedef struct packed {
    logic [3:0] op;
    logic [3:0] msel;
    logic       cord_start;
    logic       cord_head;
    logic       div_start;
    logic       div_yaw;
    logic       out_load;
  } cmd_t;

  typedef struct packed {
    logic cord_done;
    logic div_done;
  } stat_t;

  function automatic logic signed [15:0] clamp_speed(logic signed [17:0] v,
                                                     logic signed [15:0] up,
                                                     logic signed [15:0] lo);
    logic signed [15:0] r;
    if (v >= 18'(up)) begin
      r = up;
    end else if (v <= 18'(lo)) begin
      r = lo;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

  function automatic logic signed [15:0] sat16(logic signed [21:0] v);
    logic signed [15:0] r;
    if (v > 22'sd32767) begin
      r = 16'sh7fff;
    end else if (v < -22'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

endpackage

@@ rtl/kbs_if.sv @@
// Stream interfaces for the tick commands and the pose results.
interface kbs_tick_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] steer_cmd;
  logic signed [15:0] speed_cmd;
  logic signed [15:0] accel_cmd;
  modport source (output valid, steer_cmd, speed_cmd, accel_cmd, input ready);
  modport sink (input valid, steer_cmd, speed_cmd, accel_cmd, output ready);
endinterface

interface kbs_pose_if;
  logic               valid;
  logic               ready;
  logic signed [47:0] pos_x;
  logic signed [47:0] pos_y;
  logic signed [15:0] heading_out;
  logic signed [15:0] speed_out;
  logic signed [15:0] vel_x;
  logic signed [15:0] vel_y;
  logic signed [15:0] yaw_rate;
  modport source (output valid, pos_x, pos_y, heading_out, speed_out, vel_x, vel_y,
                  yaw_rate, input ready);
  modport sink (input valid, pos_x, pos_y, heading_out, speed_out, vel_x, vel_y,
                yaw_rate, output ready);
endinterface

@@ rtl/kbs_cordic.sv @@
// Iterative rotation-mode CORDIC giving Q30 cosine and sine of an angle.
module kbs_cordic (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  kbs_pkg::ang_t angle,
  output logic          done,
  output kbs_pkg::cq_t  cos_q,
  output kbs_pkg::cq_t  sin_q
);
  import kbs_pkg::*;

  cq_t x, y, z;
  cq_t z0, z_fold, dx, dy, x_it, y_it, z_it;
  logic flip, flip0, busy, last;
  logic [4:0] k;

  always_comb begin
    z0 = {angle[15], angle, 17'b0};
    z_fold = z0;
    flip0 = 1'b0;
    if (z0 > Q30_HALF_PI) begin
      z_fold = z0 - Q30_PI;
      flip0 = 1'b1;
    end else if (z0 < -Q30_HALF_PI) begin
      z_fold = z0 + Q30_PI;
      flip0 = 1'b1;
    end
    dx = y >>> k;
    dy = x >>> k;
    if (z >= 0) begin
      x_it = x - dx;
      y_it = y + dy;
      z_it = z - ATAN_TAB[k];
    end else begin
      x_it = x + dx;
      y_it = y - dy;
      z_it = z + ATAN_TAB[k];
    end
    last = (k == 5'(CORDIC_ITERATIONS - 1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        x <= Q30_GAIN;
        y <= '0;
        z <= z_fold;
        flip <= flip0;
        k <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        x <= (last && flip) ? -x_it : x_it;
        y <= (last && flip) ? -y_it : y_it;
        z <= z_it;
        k <= k + 5'd1;
        if (last) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign cos_q = x;
  assign sin_q = y;
endmodule

@@ rtl/kbs_divider.sv @@
// Restoring divider with a saturated 16-bit signed quotient, truncated toward zero.
module kbs_divider (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [51:0] num,
  input  logic signed [39:0] den,
  input  logic [15:0]        lim_pos,
  input  logic [15:0]        lim_neg,
  output logic               done,
  output logic signed [15:0] quot
);
  logic [51:0] un_c;
  logic [39:0] ud_c;
  logic [56:0] rem, dsh;
  logic [39:0] ud;
  logic [16:0] qa;
  logic [15:0] lim, qm;
  logic [4:0]  i;
  logic        neg, zero, ovf, busy, take;

  always_comb begin
    un_c = num[51] ? 52'(-num) : 52'(num);
    ud_c = den[39] ? 40'(-den) : 40'(den);
    dsh = 57'(ud) << i;
    take = (rem >= dsh);
    if (ovf || (qa > {1'b0, lim})) begin
      qm = lim;
    end else begin
      qm = qa[15:0];
    end
    if (zero) begin
      quot = '0;
    end else if (neg) begin
      quot = -qm;
    end else begin
      quot = qm;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rem <= 57'(un_c);
        ud <= ud_c;
        neg <= num[51] != den[39];
        lim <= (num[51] != den[39]) ? lim_neg : lim_pos;
        zero <= (num == '0);
        ovf <= (ud_c == '0) || ((un_c >> 17) >= 52'(ud_c));
        qa <= '0;
        i <= 5'd16;
        busy <= 1'b1;
      end else if (busy) begin
        if (take) begin
          rem <= rem - dsh;
        end
        qa <= {qa[15:0], take};
        i <= i - 5'd1;
        if (i == 5'd0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

@@ rtl/kbs_datapath.sv @@
// Datapath: vehicle state, shared multiplier, CORDIC and divider, result registers.
module kbs_datapath (
  input  logic               clk,
  input  logic               rst,
  input  kbs_pkg::cmd_t      cmd,
  input  kbs_pkg::cfg_t      cfg,
  input  logic signed [15:0] steer_cmd,
  input  logic signed [15:0] speed_cmd,
  input  logic signed [15:0] accel_cmd,
  output kbs_pkg::stat_t     stat,
  output logic signed [47:0] pos_x,
  output logic signed [47:0] pos_y,
  output logic signed [15:0] heading_out,
  output logic signed [15:0] speed_out,
  output logic signed [15:0] vel_x,
  output logic signed [15:0] vel_y,
  output logic signed [15:0] yaw_rate
);
  import kbs_pkg::*;

  logic signed [47:0] x_pos, y_pos;
  ang_t heading, speed, steer, vcmd, acmd, vx, vy, steer_c, quot;
  logic signed [17:0] ts, tc, mb, dv, vsum;
  logic signed [33:0] ss, ma;
  logic signed [51:0] mp, num;
  logic signed [39:0] den;
  logic signed [63:0] acc, rsum;
  logic signed [34:0] tsum, csum;
  logic signed [16:0] lim17, d17, hsum;
  logic signed [51:0] vr;
  cq_t c, s;

  kbs_cordic u_cordic (
    .clk(clk), .rst(rst), .start(cmd.cord_start),
    .angle(cmd.cord_head ? heading : steer),
    .done(stat.cord_done), .cos_q(c), .sin_q(s)
  );

  kbs_divider u_divider (
    .clk(clk), .rst(rst), .start(cmd.div_start), .num(num), .den(den),
    .lim_pos(cmd.div_yaw ? 16'd32767 : 16'(ANG_PI)),
    .lim_neg(cmd.div_yaw ? 16'd32768 : 16'(ANG_PI)),
    .done(stat.div_done), .quot(quot)
  );

  always_comb begin
    lim17 = {3'b0, cfg.steer_limit};
    d17 = 17'(steer_cmd);
    if (d17 >= lim17) begin
      steer_c = lim17[15:0];
    end else if (d17 <= -lim17) begin
      steer_c = 16'(-lim17);
    end else begin
      steer_c = steer_cmd;
    end
    unique case (cmd.msel)
      M_SS:     begin ma = 34'(speed); mb = {2'b0, cfg.step_time}; end
      M_SS_CH:  begin ma = ss; mb = {c[33], c[33:17]}; end
      M_SS_CL:  begin ma = ss; mb = {1'b0, c[16:0]}; end
      M_SS_SH:  begin ma = ss; mb = {s[33], s[33:17]}; end
      M_SS_SL:  begin ma = ss; mb = {1'b0, s[16:0]}; end
      M_SS_TS:  begin ma = ss; mb = ts; end
      M_WB_TC:  begin ma = {18'b0, cfg.wheel_base}; mb = tc; end
      M_ACC_ST: begin ma = 34'(acmd); mb = {2'b0, cfg.step_time}; end
      M_SPD_C:  begin ma = c; mb = 18'(speed); end
      M_SPD_S:  begin ma = s; mb = 18'(speed); end
      M_SPD_TS: begin ma = 34'(speed); mb = ts; end
      default:  begin ma = '0; mb = '0; end
    endcase
    tsum = 35'(s) + 35'sd8192;
    csum = 35'(c) + 35'sd8192;
    rsum = acc + 64'(mp) + (64'sd1 <<< 39);
    hsum = 17'(heading) + 17'(quot);
    dv = 18'((signed'(mp[33:0]) + 34'sd32768) >>> 16);
    vsum = 18'(speed) + dv;
    vr = mp + (52'sd1 <<< 29);
  end

  always_ff @(posedge clk) begin
    mp <= ma * mb;
    if (rst) begin
      x_pos <= '0;
      y_pos <= '0;
      heading <= ANG_PI;
      speed <= '0;
    end else begin
      unique case (cmd.op)
        OP_LOAD: begin
          steer <= steer_c;
          vcmd <= speed_cmd;
          acmd <= accel_cmd;
        end
        OP_TAN: begin
          ts <= tsum[31:14];
          tc <= csum[31:14];
        end
        OP_SPEED_CMD: speed <= clamp_speed(18'(vcmd), cfg.speed_upper, cfg.speed_lower);
        OP_SS:   ss <= mp[33:0];
        OP_HIGH: acc <= 64'(mp) <<< 17;
        OP_XL:   x_pos <= x_pos + {{24{rsum[63]}}, rsum[63:40]};
        OP_YL:   y_pos <= y_pos + {{24{rsum[63]}}, rsum[63:40]};
        OP_NUM:  num <= mp;
        OP_DEN:  den <= {mp[36:0], 3'b0};
        OP_HEAD: begin
          if (hsum > 17'(ANG_PI)) begin
            heading <= 16'(hsum - ANG_TWO_PI);
          end else if (hsum < -17'(ANG_PI)) begin
            heading <= 16'(hsum + ANG_TWO_PI);
          end else begin
            heading <= hsum[15:0];
          end
        end
        OP_ACC_UPD: speed <= clamp_speed(vsum, cfg.speed_upper, cfg.speed_lower);
        OP_VX:   vx <= sat16(vr[51:30]);
        OP_VY:   vy <= sat16(vr[51:30]);
        OP_YNUM: num <= {mp[41:0], 10'b0};
        OP_YDEN: den <= 40'(mp);
        default: ;
      endcase
    end
    if (cmd.out_load) begin
      pos_x <= x_pos;
      pos_y <= y_pos;
      heading_out <= heading;
      speed_out <= speed;
      vel_x <= vx;
      vel_y <= vy;
      yaw_rate <= quot;
    end
  end
endmodule

@@ rtl/kbs_ctrl.sv @@
// Controller state machine sequencing one simulation tick through the datapath.
module kbs_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  input  logic           accel_mode,
  input  kbs_pkg::stat_t stat,
  output kbs_pkg::cmd_t  cmd
);
  import kbs_pkg::*;

  localparam logic [4:0] S_IDLE = 5'd0,  S_CS  = 5'd1,  S_CSW = 5'd2,  S_SPD = 5'd3,
                         S_ADV  = 5'd4,  S_ADVW = 5'd5, S_A1  = 5'd6,  S_A2  = 5'd7,
                         S_A3   = 5'd8,  S_A4  = 5'd9,  S_A5  = 5'd10, S_A6  = 5'd11,
                         S_A7   = 5'd12, S_A8  = 5'd13, S_A9  = 5'd14, S_A10 = 5'd15,
                         S_B1   = 5'd16, S_B2  = 5'd17, S_C   = 5'd18, S_CW  = 5'd19,
                         S_C1   = 5'd20, S_C2  = 5'd21, S_C3  = 5'd22, S_C4  = 5'd23,
                         S_C5   = 5'd24, S_C6  = 5'd25, S_FIN = 5'd26;

  logic [4:0] state, state_next;
  logic fin_fire;

  assign in_ready = (state == S_IDLE);
  assign fin_fire = (state == S_FIN) && (!out_valid || out_ready);

  always_comb begin
    state_next = state;
    cmd = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op = OP_LOAD;
          state_next = S_CS;
        end
      end
      S_CS: begin
        cmd.cord_start = 1'b1;
        state_next = S_CSW;
      end
      S_CSW: begin
        if (stat.cord_done) begin
          cmd.op = OP_TAN;
          state_next = accel_mode ? S_ADV : S_SPD;
        end
      end
      S_SPD: begin
        cmd.op = OP_SPEED_CMD;
        state_next = S_ADV;
      end
      S_ADV: begin
        cmd.cord_start = 1'b1;
        cmd.cord_head = 1'b1;
        state_next = S_ADVW;
      end
      S_ADVW: begin
        if (stat.cord_done) begin
          cmd.msel = M_SS;
          state_next = S_A1;
        end
      end
      S_A1: begin cmd.op = OP_SS; state_next = S_A2; end
      S_A2: begin cmd.msel = M_SS_CH; state_next = S_A3; end
      S_A3: begin cmd.op = OP_HIGH; cmd.msel = M_SS_CL; state_next = S_A4; end
      S_A4: begin cmd.op = OP_XL; cmd.msel = M_SS_SH; state_next = S_A5; end
      S_A5: begin cmd.op = OP_HIGH; cmd.msel = M_SS_SL; state_next = S_A6; end
      S_A6: begin cmd.op = OP_YL; cmd.msel = M_SS_TS; state_next = S_A7; end
      S_A7: begin cmd.op = OP_NUM; cmd.msel = M_WB_TC; state_next = S_A8; end
      S_A8: begin cmd.op = OP_DEN; state_next = S_A9; end
      S_A9: begin cmd.div_start = 1'b1; state_next = S_A10; end
      S_A10: begin
        if (stat.div_done) begin
          cmd.op = OP_HEAD;
          state_next = accel_mode ? S_B1 : S_C;
        end
      end
      S_B1: begin cmd.msel = M_ACC_ST; state_next = S_B2; end
      S_B2: begin cmd.op = OP_ACC_UPD; state_next = S_C; end
      S_C: begin
        cmd.cord_start = 1'b1;
        cmd.cord_head = 1'b1;
        state_next = S_CW;
      end
      S_CW: begin
        if (stat.cord_done) begin
          cmd.msel = M_SPD_C;
          state_next = S_C1;
        end
      end
      S_C1: begin cmd.op = OP_VX; cmd.msel = M_SPD_S; state_next = S_C2; end
      S_C2: begin cmd.op = OP_VY; cmd.msel = M_SPD_TS; state_next = S_C3; end
      S_C3: begin cmd.op = OP_YNUM; cmd.msel = M_WB_TC; state_next = S_C4; end
      S_C4: begin cmd.op = OP_YDEN; state_next = S_C5; end
      S_C5: begin cmd.div_start = 1'b1; cmd.div_yaw = 1'b1; state_next = S_C6; end
      S_C6: begin
        if (stat.div_done) begin
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        if (fin_fire) begin
          cmd.out_load = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (fin_fire) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end
endmodule

@@ rtl/kinematic_bicycle_step_core.sv @@
// Top level of the kinematic bicycle step core with its APB register file.
// Each tick transaction advances the vehicle by one Euler step and yields one pose
// transaction. A tick makes three passes through the shared CORDIC unit (steering,
// old heading, new heading), two through the 17-step divider (heading increment,
// yaw rate) and the multiply steps between them. Ticks are processed one at a time,
// so a new tick is accepted only once the previous one is finished; it is accepted
// while the previous pose still waits in the output register.
module kinematic_bicycle_step_core (
  input  logic        clk,
  input  logic        rst,
  kbs_tick_if.sink    tick,
  kbs_pose_if.source  pose,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import kbs_pkg::*;

  cfg_t  cfg;
  cmd_t  cmd;
  stat_t stat;
  logic [2:0] idx;

  assign pready = 1'b1;
  assign idx = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.step_time <= 16'd655;
      cfg.wheel_base <= 16'd2560;
      cfg.steer_limit <= 14'd6434;
      cfg.speed_upper <= 16'sd15645;
      cfg.speed_lower <= -16'sd5688;
      cfg.accel_mode <= 1'b0;
    end else if (psel && penable && pwrite) begin
      unique case (idx)
        REG_STEP_TIME:   cfg.step_time <= pwdata[15:0];
        REG_WHEEL_BASE:  cfg.wheel_base <= pwdata[15:0];
        REG_STEER_LIMIT: cfg.steer_limit <= pwdata[13:0];
        REG_SPEED_UPPER: cfg.speed_upper <= pwdata[15:0];
        REG_SPEED_LOWER: cfg.speed_lower <= pwdata[15:0];
        REG_ACCEL_MODE:  cfg.accel_mode <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_STEP_TIME:   prdata = {16'b0, cfg.step_time};
      REG_WHEEL_BASE:  prdata = {16'b0, cfg.wheel_base};
      REG_STEER_LIMIT: prdata = {18'b0, cfg.steer_limit};
      REG_SPEED_UPPER: prdata = 32'(cfg.speed_upper);
      REG_SPEED_LOWER: prdata = 32'(cfg.speed_lower);
      REG_ACCEL_MODE:  prdata = {31'b0, cfg.accel_mode};
      default:         prdata = '0;
    endcase
  end

  kbs_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(tick.valid), .in_ready(tick.ready),
    .out_valid(pose.valid), .out_ready(pose.ready), .accel_mode(cfg.accel_mode),
    .stat(stat), .cmd(cmd)
  );

  kbs_datapath u_datapath (
    .clk(clk), .rst(rst), .cmd(cmd), .cfg(cfg),
    .steer_cmd(tick.steer_cmd), .speed_cmd(tick.speed_cmd), .accel_cmd(tick.accel_cmd),
    .stat(stat), .pos_x(pose.pos_x), .pos_y(pose.pos_y),
    .heading_out(pose.heading_out), .speed_out(pose.speed_out),
    .vel_x(pose.vel_x), .vel_y(pose.vel_y), .yaw_rate(pose.yaw_rate)
  );
endmodule

@@ sim/kbs_tb_if.sv @@
`timescale 1ns / 100ps
// Control signals shared between the testbench stimulus and its pose receiver.
interface kbs_tb_ctrl_if;
  logic hold;
endinterface

@@ sim/kinematic_bicycle_step_core_tb.sv @@
`timescale 1ns / 100ps
// Testbench for the kinematic bicycle step core: directed and random ticks checked against a predictor.
module kinematic_bicycle_step_core_tb;
  import kbs_pkg::*;

  typedef struct {
    logic signed [15:0] steer;
    logic signed [15:0] spd;
    logic signed [15:0] acc;
  } tick_t;

  typedef struct packed {
    logic [47:0] px;
    logic [47:0] py;
    logic signed [15:0] hd;
    logic signed [15:0] sp;
    logic signed [15:0] vx;
    logic signed [15:0] vy;
    logic signed [15:0] yr;
  } pose_t;

  typedef struct {
    logic signed [15:0] steer;
    logic signed [15:0] spd;
    logic signed [15:0] acc;
    logic        known;
    pose_t       want;
  } row_t;

  localparam int LIMIT = 3000000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [4:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  kbs_tick_if tick ();
  kbs_pose_if pose ();
  kbs_tb_ctrl_if ctl ();

  kinematic_bicycle_step_core i_dut (
    .clk(clk), .rst(rst), .tick(tick.sink), .pose(pose.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  logic [47:0] m_x, m_y;
  logic signed [15:0] m_head, m_speed;
  logic [15:0] c_step, c_wb;
  logic [13:0] c_steer;
  logic signed [15:0] c_up, c_lo;
  logic c_acc;

  pose_t poses_due[$];
  int errors = 0;
  int cycles = 0;
  int hold_left = 0;
  bit quiet_out = 0;

  assign ctl.hold = (hold_left > 0);

  function automatic longint ashr(longint v, int s);
    return v >>> s;
  endfunction

  task automatic cordic(input int ang, output longint c, output longint s);
    longint z, x, y, dx, dy;
    bit flip;
    z = longint'(ang) * 131072;
    x = 652032874;
    y = 0;
    flip = 0;
    if (z > 64'sd1686629713) begin
      z -= 64'sd3373259426;
      flip = 1;
    end else if (z < -64'sd1686629713) begin
      z += 64'sd3373259426;
      flip = 1;
    end
    for (int i = 0; i < CORDIC_ITERATIONS; i++) begin
      dx = ashr(y, i);
      dy = ashr(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= longint'(ATAN_TAB[i]);
      end else begin
        x += dx; y -= dy; z += longint'(ATAN_TAB[i]);
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endtask

  function automatic int sat_quot(longint num, longint den, longint lp, longint ln);
    bit neg;
    longint un, ud, q, lim;
    if (num == 0) return 0;
    neg = (num < 0) != (den < 0);
    un = num < 0 ? -num : num;
    ud = den < 0 ? -den : den;
    lim = neg ? ln : lp;
    q = (ud == 0) ? lim : un / ud;
    if (q > lim) q = lim;
    return neg ? -int'(q) : int'(q);
  endfunction

  function automatic int clamp_v(int v);
    if (v >= c_up) return c_up;
    if (v <= c_lo) return c_lo;
    return v;
  endfunction

  function automatic int sat_16(longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return int'(v);
  endfunction

  task automatic move_pose(input int ts, input int tc);
    longint c, s, num, den;
    int dh, h;
    cordic(m_head, c, s);
    m_x = m_x + 48'(ashr(longint'(m_speed) * c * longint'(c_step) + (64'sd1 <<< 39), 40));
    m_y = m_y + 48'(ashr(longint'(m_speed) * s * longint'(c_step) + (64'sd1 <<< 39), 40));
    num = longint'(m_speed) * ts * longint'(c_step);
    den = longint'(c_wb) * tc * 8;
    dh = sat_quot(num, den, 25736, 25736);
    h = m_head + dh;
    if (h > 25736) h -= 51472;
    else if (h < -25736) h += 51472;
    m_head = 16'(h);
  endtask

  task automatic predict_pose(input tick_t t, output pose_t p);
    int d, ts, tc, dv;
    longint dc, ds, c, s;
    d = int'(t.steer);
    if (d >= int'(c_steer)) d = int'(c_steer);
    else if (d <= -int'(c_steer)) d = -int'(c_steer);
    cordic(d, dc, ds);
    ts = int'(ashr(ds + 8192, 14));
    tc = int'(ashr(dc + 8192, 14));
    if (c_acc) begin
      move_pose(ts, tc);
      dv = int'(ashr(longint'(t.acc) * longint'(c_step) + 32768, 16));
      m_speed = 16'(clamp_v(m_speed + dv));
    end else begin
      m_speed = 16'(clamp_v(int'(t.spd)));
      move_pose(ts, tc);
    end
    cordic(m_head, c, s);
    p.px = m_x;
    p.py = m_y;
    p.hd = m_head;
    p.sp = m_speed;
    p.vx = 16'(sat_16(ashr(longint'(m_speed) * c + (64'sd1 <<< 29), 30)));
    p.vy = 16'(sat_16(ashr(longint'(m_speed) * s + (64'sd1 <<< 29), 30)));
    p.yr = 16'(sat_quot(longint'(m_speed) * ts * 1024, longint'(c_wb) * tc, 32767, 32768));
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 2'b00}; pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    case (idx)
      REG_STEP_TIME:   c_step = val[15:0];
      REG_WHEEL_BASE:  c_wb = val[15:0];
      REG_STEER_LIMIT: c_steer = val[13:0];
      REG_SPEED_UPPER: c_up = val[15:0];
      REG_SPEED_LOWER: c_lo = val[15:0];
      REG_ACCEL_MODE:  c_acc = val[0];
      default: ;
    endcase
  endtask

  task automatic settle;
    tick.valid <= 1'b0;
    while (poses_due.size() != 0) @(posedge clk);
    repeat (150) @(posedge clk);
  endtask

  task automatic write_all(input logic [15:0] st, input logic [15:0] wb, input logic [13:0] sl,
                           input logic [15:0] up, input logic [15:0] lo, input logic am);
    settle();
    write_reg(REG_STEP_TIME, 32'(st));
    write_reg(REG_WHEEL_BASE, 32'(wb));
    write_reg(REG_STEER_LIMIT, 32'(sl));
    write_reg(REG_SPEED_UPPER, 32'(up));
    write_reg(REG_SPEED_LOWER, 32'(lo));
    write_reg(REG_ACCEL_MODE, 32'(am));
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  task automatic send_tick(input tick_t t, input bit gaps);
    pose_t p;
    while (gaps && $urandom_range(99) < 25) begin
      tick.valid <= 1'b0;
      @(posedge clk);
    end
    tick.valid <= 1'b1;
    tick.steer_cmd <= t.steer;
    tick.speed_cmd <= t.spd;
    tick.accel_cmd <= t.acc;
    @(posedge clk);
    while (!tick.ready) @(posedge clk);
    predict_pose(t, p);
    poses_due.push_back(p);
  endtask

  function automatic tick_t rand_tick();
    tick_t t;
    t.steer = $urandom_range(3) == 0 ? 16'($urandom) : 16'($urandom_range(12000) - 6000);
    t.spd = $urandom_range(3) == 0 ? 16'($urandom) : 16'($urandom_range(24000) - 8000);
    t.acc = 16'($urandom);
    return t;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      pose.ready <= 1'b0;
    end else if (ctl.hold) begin
      pose.ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else begin
      pose.ready <= quiet_out ? 1'b1 : ($urandom_range(99) >= 25);
    end
  end

  always @(posedge clk) begin
    pose_t w;
    if (!rst && pose.valid && pose.ready) begin
      if (poses_due.size() == 0) begin
        $display("%0t: unexpected pose, actual x %h", $realtime, pose.pos_x);
        errors++;
      end else begin
        w = poses_due.pop_front();
        if (pose.pos_x !== w.px || pose.pos_y !== w.py || pose.heading_out !== w.hd ||
            pose.speed_out !== w.sp || pose.vel_x !== w.vx || pose.vel_y !== w.vy ||
            pose.yaw_rate !== w.yr) begin
          $display("%0t: mismatch expected %h %h %0d %0d %0d %0d %0d actual %h %h %0d %0d %0d %0d %0d",
                   $realtime, w.px, w.py, w.hd, w.sp, w.vx, w.vy, w.yr, pose.pos_x,
                   pose.pos_y, pose.heading_out, pose.speed_out, pose.vel_x, pose.vel_y,
                   pose.yaw_rate);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  row_t rows[$];

  function automatic row_t mk(int st, int sp, int ac, bit k, pose_t w);
    row_t r;
    r.steer = 16'(st); r.spd = 16'(sp); r.acc = 16'(ac); r.known = k; r.want = w;
    return r;
  endfunction

  initial begin
    tick_t t;
    pose_t p, z;
    tick.valid <= 1'b0;
    tick.steer_cmd <= '0;
    tick.speed_cmd <= '0;
    tick.accel_cmd <= '0;
    z = '{default: '0};
    m_x = '0; m_y = '0; m_head = 16'sd25736; m_speed = '0;
    c_step = 16'd655; c_wb = 16'd2560; c_steer = 14'd6434;
    c_up = 16'sd15645; c_lo = -16'sd5688; c_acc = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // After reset a zero-speed tick leaves the pose at rest facing pi.
    p = z; p.hd = 16'sd25736;
    rows.push_back(mk(0, 0, 0, 1, p));
    rows.push_back(mk(32767, 32767, 0, 0, z));
    rows.push_back(mk(-32768, -32768, 0, 0, z));
    rows.push_back(mk(6434, 15645, 0, 0, z));
    rows.push_back(mk(-6434, -5688, 0, 0, z));
    rows.push_back(mk(100, 1000, 0, 0, z));
    rows.push_back(mk(-1, -1, -1, 0, z));
    foreach (rows[i]) begin
      t.steer = rows[i].steer; t.spd = rows[i].spd; t.acc = rows[i].acc;
      send_tick(t, 0);
      if (rows[i].known && poses_due[$] != rows[i].want) begin
        $display("%0t: directed row %0d predictor disagrees", $realtime, i);
        errors++;
      end
    end
    // Acceleration mode with extreme accelerations and a steering bound above pi/2.
    write_all(65535, 1, 14000 & 16'h3fff, 32767, -32768, 1);
    t = '{32767, 0, 32767}; send_tick(t, 0);
    t = '{-32768, 0, -32768}; send_tick(t, 0);
    t = '{12868, 0, 5000}; send_tick(t, 0);
    // Zero step time: nothing moves.
    write_all(0, 65535, 0, 100, 200, 0);
    t = '{5000, 300, 0}; send_tick(t, 0);
    t = '{-5000, 150, 7}; send_tick(t, 0);
    write_all(1, 2560, 11000, -32768, 32767, 1);
    t = '{11000, 0, 32767}; send_tick(t, 0);
    t = '{-12000, 0, -100}; send_tick(t, 0);
    write_all(655, 2560, 6434, 15645, -5688, 0);
    quiet_out = 1;
    for (int i = 0; i < 120; i++) send_tick(rand_tick(), 0);
    quiet_out = 0;
    hold_left = 2000;
    for (int i = 0; i < 6; i++) send_tick(rand_tick(), 0);
    settle();
    for (int ph = 0; ph < 6; ph++) begin
      write_all(ph == 0 ? 16'd65535 : 16'($urandom_range(65535, 1)),
                ph == 1 ? 16'd1 : 16'($urandom_range(65535, 1)),
                ph == 2 ? 14'd11000 : 14'($urandom_range(11000)),
                16'($urandom_range(32767, 0)), 16'(-int'($urandom_range(32768))),
                ph[0]);
      for (int i = 0; i < 137; i++) send_tick(rand_tick(), 1);
    end
    settle();
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
